/* rtl/sum_checked_frame_receiver_top_macros.svh */
// assertion macros for the sum-checked frame receiver
// used by sum_checked_frame_receiver_top; expects clk and rst_n in scope
`ifndef SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH
`define SUM_CHECKED_FRAME_RECEIVER_TOP_MACROS_SVH

`ifndef SYNTH
// property checked every clock outside reset
`define SCFR_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scfr assertion failed");
// condition that must hold in the cycle after a trigger
`define SCFR_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("scfr assertion failed");
`else
`define SCFR_ASSERT(label, prop)
`define SCFR_ASSERT_NEXT(label, trig, cons)
`endif

`endif

/* rtl/scfr_pkg.sv */
// shared types and constants for the sum-checked frame receiver
// no dependencies; imported by every module of the block
package scfr_pkg;

    // parser phase of the front end
    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } phase_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_TYPE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPECTED_SEQ    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SESSION_RANDOM  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_BODY_LENGTH = 2'd3;

    // frame status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CHECKSUM = 3'd1;
    localparam logic [2:0] ST_SEQUENCE = 3'd2;
    localparam logic [2:0] ST_RANDOM   = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;

    // frame layout
    localparam logic [15:0] MIN_BODY_LENGTH = 16'd5;
    localparam logic [16:0] HEADER_BYTES    = 17'd3;
    localparam logic [16:0] FRAME_OVERHEAD  = 17'd4;
    localparam logic [16:0] RAND_FIRST_POS  = 17'd3;
    localparam logic [16:0] RAND_LAST_POS   = 17'd6;
    localparam logic [16:0] SEQ_POS         = 17'd7;

    // word passed from front end to back end
    typedef struct packed {
        logic        start;     // header word: data is the length field
        logic [15:0] data;      // length field or body byte
        logic [7:0]  init_sum;  // sum of type and length bytes
        logic        is_rand;   // body byte belongs to the random
        logic        is_seq;    // body byte is the sequence byte
        logic        is_last;   // last byte of the frame
    } entry_t;

endpackage

/* rtl/sum_checked_frame_receiver_top.sv */
// Sum-checked frame receiver: takes one received byte per clock while in_ready
// is high, hunts for the frame type byte, checks the big-endian length against
// max_body_length and reports one status word at each frame end (0 ok,
// 1 checksum, 2 sequence, 3 random, 4 too short). Throughput is one byte every
// clock, set by the single-byte parser update in the front end; the back end
// consumes one queued word per clock. The result is registered when the last
// word is popped. While a finished result waits on out_ready the back end
// keeps draining body words, so input stalls only once the next frame's last
// word reaches the queue head and the QUEUE_DEPTH-word queue behind it fills.
// Registers are written through cfg_we/cfg_index/cfg_data and should be
// changed only while idle.
// Depends on scfr_pkg, scfr_front, scfr_fifo, scfr_back and the macro header.
`include "sum_checked_frame_receiver_top_macros.svh"

module sum_checked_frame_receiver_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [scfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [scfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       status,
    output logic [15:0]                      body_length,
    output logic [7:0]                       seen_seq
);
    import scfr_pkg::*;

    logic [7:0]  frame_type_reg;
    logic [7:0]  expected_seq_reg;
    logic [31:0] session_random_reg;
    logic [15:0] max_body_length_reg;
    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    entry_t      q_push_entry;
    entry_t      q_head;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_type_reg      <= '0;
            expected_seq_reg    <= '0;
            session_random_reg  <= '0;
            max_body_length_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FRAME_TYPE:      frame_type_reg      <= cfg_data[7:0];
                CFG_EXPECTED_SEQ:    expected_seq_reg    <= cfg_data[7:0];
                CFG_SESSION_RANDOM:  session_random_reg  <= cfg_data[31:0];
                CFG_MAX_BODY_LENGTH: max_body_length_reg <= cfg_data[15:0];
                default:             frame_type_reg      <= frame_type_reg;
            endcase
        end
    end

    // parser
    scfr_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .frame_type      (frame_type_reg),
        .max_body_length (max_body_length_reg),
        .q_full          (q_full),
        .push            (q_push),
        .push_entry      (q_push_entry)
    );

    // word queue
    scfr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .empty      (q_empty),
        .head       (q_head)
    );

    // checker and result register
    scfr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (q_empty),
        .head           (q_head),
        .pop            (q_pop),
        .expected_seq   (expected_seq_reg),
        .session_random (session_random_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .body_length    (body_length),
        .seen_seq       (seen_seq)
    );

    // result consistency checks
    `SCFR_ASSERT(a_short_matches_length, out_valid |-> ((status == ST_SHORT) == (body_length < MIN_BODY_LENGTH)))
    `SCFR_ASSERT(a_ok_has_expected_seq, (out_valid && status == ST_OK) |-> (seen_seq == expected_seq_reg))
    `SCFR_ASSERT(a_status_in_range, out_valid |-> (status <= ST_SHORT))
    `SCFR_ASSERT_NEXT(a_queue_pop_when_empty, q_empty && !q_push, !q_pop || !q_empty)

endmodule

/* rtl/scfr_fifo.sv */
// short word queue between front end and back end of the frame receiver
// depends on scfr_pkg for the entry type
module scfr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  scfr_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output scfr_pkg::entry_t head
);
    import scfr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    // status
    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/scfr_front.sv */
// front end of the frame receiver: hunts the type byte, checks the length
// and tags each frame byte; depends on scfr_pkg
module scfr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       rx_byte,
    input  logic [7:0]       frame_type,
    input  logic [15:0]      max_body_length,
    input  logic             q_full,
    output logic             push,
    output scfr_pkg::entry_t push_entry
);
    import scfr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  held_hi_reg, held_hi_next;
    logic [7:0]  sum_reg, sum_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] len_reg, len_next;
    logic        accept;
    logic        over_limit;
    logic        hi_is_type;
    logic        lo_is_type;
    logic [16:0] pos_inc;
    logic        at_last;

    // common decodes
    assign in_ready   = !q_full;
    assign accept     = in_valid && !q_full;
    assign over_limit = ({held_hi_reg, rx_byte} > max_body_length);
    assign hi_is_type = (held_hi_reg == frame_type);
    assign lo_is_type = (rx_byte == frame_type);
    assign pos_inc    = pos_reg + 17'd1;
    assign at_last    = (pos_inc >= ({1'b0, len_reg} + FRAME_OVERHEAD));

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (lo_is_type)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI:
                begin
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (!over_limit)
                    begin
                        phase_next = PH_BODY;
                    end
                    else if (hi_is_type)
                    begin
                        phase_next = PH_LEN_LO;
                    end
                    else if (lo_is_type)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_BODY:
                begin
                    if (at_last)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
                default:
                begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

    // datapath and queue word
    always_comb
    begin
        held_hi_next = held_hi_reg;
        sum_next     = sum_reg;
        pos_next     = pos_reg;
        len_next     = len_reg;
        push         = 1'b0;
        push_entry   = '0;
        if (accept)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    sum_next = rx_byte;
                end
                PH_LEN_HI:
                begin
                    held_hi_next = rx_byte;
                    sum_next     = sum_reg + rx_byte;
                end
                PH_LEN_LO:
                begin
                    if (!over_limit)
                    begin
                        len_next            = {held_hi_reg, rx_byte};
                        pos_next            = HEADER_BYTES;
                        push                = 1'b1;
                        push_entry.start    = 1'b1;
                        push_entry.data     = {held_hi_reg, rx_byte};
                        push_entry.init_sum = sum_reg + rx_byte;
                    end
                    else if (hi_is_type)
                    begin
                        // high length byte restarts a frame, low byte is its high length
                        held_hi_next = rx_byte;
                        sum_next     = held_hi_reg + rx_byte;
                    end
                    else
                    begin
                        sum_next = rx_byte;
                    end
                end
                PH_BODY:
                begin
                    pos_next           = pos_inc;
                    push               = 1'b1;
                    push_entry.data    = {8'd0, rx_byte};
                    push_entry.is_rand = (pos_reg >= RAND_FIRST_POS)
                                         && (pos_reg <= RAND_LAST_POS);
                    push_entry.is_seq  = (pos_reg == SEQ_POS);
                    push_entry.is_last = at_last;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            held_hi_reg <= '0;
            sum_reg     <= '0;
            pos_reg     <= '0;
            len_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            held_hi_reg <= held_hi_next;
            sum_reg     <= sum_next;
            pos_reg     <= pos_next;
            len_reg     <= len_next;
        end
    end

endmodule

/* rtl/scfr_back.sv */
// back end of the frame receiver: sums the frame, captures random and
// sequence, and registers one status word per frame; depends on scfr_pkg
module scfr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  scfr_pkg::entry_t head,
    output logic             pop,
    input  logic [7:0]       expected_seq,
    input  logic [31:0]      session_random,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       status,
    output logic [15:0]      body_length,
    output logic [7:0]       seen_seq
);
    import scfr_pkg::*;

    logic [7:0]  sum_reg, sum_next;
    logic [31:0] rand_reg, rand_next;
    logic [7:0]  seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  status_reg, status_next;
    logic [15:0] body_length_reg, body_length_next;
    logic [7:0]  seen_seq_reg, seen_seq_next;
    logic [7:0]  sum_upd;
    logic [31:0] rand_upd;
    logic [7:0]  seq_upd;
    logic [2:0]  status_calc;

    // a last word waits while the output register is still occupied
    assign pop = !empty && (!head.is_last || !out_valid_reg || out_ready);

    // running values including the current byte
    assign sum_upd  = sum_reg + head.data[7:0];
    assign rand_upd = head.is_rand ? {rand_reg[23:0], head.data[7:0]} : rand_reg;
    assign seq_upd  = head.is_seq ? head.data[7:0] : seq_reg;

    // status priority: short, checksum, sequence, random
    always_comb
    begin
        if (len_reg < MIN_BODY_LENGTH)
        begin
            status_calc = ST_SHORT;
        end
        else if (sum_upd != 8'd0)
        begin
            status_calc = ST_CHECKSUM;
        end
        else if (seq_upd != expected_seq)
        begin
            status_calc = ST_SEQUENCE;
        end
        else if (rand_upd != session_random)
        begin
            status_calc = ST_RANDOM;
        end
        else
        begin
            status_calc = ST_OK;
        end
    end

    // accumulate and finish
    always_comb
    begin
        sum_next         = sum_reg;
        rand_next        = rand_reg;
        seq_next         = seq_reg;
        len_next         = len_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        body_length_next = body_length_reg;
        seen_seq_next    = seen_seq_reg;
        if (pop)
        begin
            if (head.start)
            begin
                sum_next  = head.init_sum;
                rand_next = '0;
                seq_next  = '0;
                len_next  = head.data;
            end
            else
            begin
                sum_next  = sum_upd;
                rand_next = rand_upd;
                seq_next  = seq_upd;
                if (head.is_last)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = status_calc;
                    body_length_next = len_reg;
                    seen_seq_next    = seq_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            rand_reg      <= '0;
            seq_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            rand_reg      <= rand_next;
            seq_reg       <= seq_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        body_length_reg <= body_length_next;
        seen_seq_reg    <= seen_seq_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign body_length = body_length_reg;
    assign seen_seq    = seen_seq_reg;

endmodule

/* tb/tb_sum_checked_frame_receiver_top.sv */
// testbench for sum_checked_frame_receiver_top: framed byte streams with random idling on both sides
// each status word is checked against an in-bench frame parser with its own register copy
// depends on scfr_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_sum_checked_frame_receiver_top;
    import scfr_pkg::*;

    localparam int ITEM_TARGET      = 1550;
    localparam int FINAL_LEN        = 300;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int SETTLE_CYCLES    = 16;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int REPORT_LIMIT     = 10;

    typedef struct {
        logic [2:0]  status;
        logic [15:0] body_length;
        logic [7:0]  seen_seq;
    } status_word_t;

    typedef enum {
        FK_OK,
        FK_BAD_SUM,
        FK_BAD_SEQ,
        FK_BAD_RANDOM,
        FK_SHORT,
        FK_OVER_LIMIT
    } frame_kind_t;

    // frame parser model and the status words it still awaits
    class frame_status_board;
        logic [7:0]   cfg_type;
        logic [7:0]   cfg_seq;
        logic [31:0]  cfg_random;
        logic [15:0]  cfg_max_len;
        phase_t       ph;
        logic [7:0]   len_hi;
        logic [15:0]  len;
        logic [16:0]  pos;
        logic [7:0]   sum;
        logic [31:0]  rnd;
        logic [7:0]   seq;
        status_word_t awaited_words[$];
        int           mismatches;

        function new();
            cfg_type    = 8'h00;
            cfg_seq     = 8'h00;
            cfg_random  = 32'h0;
            cfg_max_len = 16'hFFFF;
            ph          = PH_HUNT;
            len_hi      = 8'h00;
            len         = 16'h0;
            pos         = 17'h0;
            sum         = 8'h00;
            rnd         = 32'h0;
            seq         = 8'h00;
            mismatches  = 0;
        endfunction

        function void set_reg(input logic [CFG_INDEX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FRAME_TYPE:      cfg_type    = data[7:0];
                CFG_EXPECTED_SEQ:    cfg_seq     = data[7:0];
                CFG_SESSION_RANDOM:  cfg_random  = data;
                CFG_MAX_BODY_LENGTH: cfg_max_len = data[15:0];
                default: ;
            endcase
        endfunction

        function void open_frame(input logic [7:0] b);
            ph  = PH_LEN_HI;
            sum = b;
            rnd = 32'h0;
            seq = 8'h00;
            pos = 17'd1;
        endfunction

        // advance the parser by one accepted byte
        function void note_rx_byte(input logic [7:0] b);
            logic [15:0]  hdr_len;
            status_word_t w;
            case (ph)
                PH_HUNT:
                begin
                    if (b == cfg_type)
                        open_frame(b);
                end
                PH_LEN_HI:
                begin
                    len_hi = b;
                    sum    = sum + b;
                    pos    = 17'd2;
                    ph     = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    hdr_len = {len_hi, b};
                    if (hdr_len > cfg_max_len)
                    begin
                        // rejected header: length bytes are retried as type bytes
                        if (len_hi == cfg_type)
                        begin
                            open_frame(len_hi);
                            len_hi = b;
                            sum    = sum + b;
                            pos    = 17'd2;
                            ph     = PH_LEN_LO;
                        end
                        else if (b == cfg_type)
                            open_frame(b);
                        else
                            ph = PH_HUNT;
                    end
                    else
                    begin
                        len = hdr_len;
                        sum = sum + b;
                        pos = HEADER_BYTES;
                        ph  = PH_BODY;
                    end
                end
                default:
                begin
                    sum = sum + b;
                    if (pos >= RAND_FIRST_POS && pos <= RAND_LAST_POS)
                        rnd = {rnd[23:0], b};
                    else if (pos == SEQ_POS)
                        seq = b;
                    pos = pos + 17'd1;
                    if (pos >= {1'b0, len} + FRAME_OVERHEAD)
                    begin
                        // frame end: one status word, highest priority error wins
                        ph = PH_HUNT;
                        if (len < MIN_BODY_LENGTH)
                            w.status = ST_SHORT;
                        else if (sum != 8'h00)
                            w.status = ST_CHECKSUM;
                        else if (seq != cfg_seq)
                            w.status = ST_SEQUENCE;
                        else if (rnd != cfg_random)
                            w.status = ST_RANDOM;
                        else
                            w.status = ST_OK;
                        w.body_length = len;
                        w.seen_seq    = seq;
                        awaited_words.push_back(w);
                    end
                end
            endcase
        endfunction

        function void flag_mismatch(input string what);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch at %0t: %s", $time, what);
        endfunction

        // compare one accepted status word with the oldest one awaited
        function void check_status_word(input logic [2:0] st, input logic [15:0] blen,
                                        input logic [7:0] sseq);
            status_word_t w;
            if (awaited_words.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected word status=%0d length=%0d seq=%0d",
                                        st, blen, sseq));
                return;
            end
            w = awaited_words.pop_front();
            if (w.status !== st || w.body_length !== blen || w.seen_seq !== sseq)
                flag_mismatch($sformatf(
                    "expected status=%0d length=%0d seq=%0d, got status=%0d length=%0d seq=%0d",
                    w.status, w.body_length, w.seen_seq, st, blen, sseq));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic [7:0]             rx_byte;
    logic                   out_valid;
    logic                   out_ready;
    logic [2:0]             status;
    logic [15:0]            body_length;
    logic [7:0]             seen_seq;

    frame_status_board sb;
    logic [7:0]        tx_bytes[$];
    int                frame_bytes;
    bit                idling_on;
    bit                hold_long_req;

    sum_checked_frame_receiver_top u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .body_length (body_length),
        .seen_seq    (seen_seq)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_reg(idx, data);
    endtask

    task automatic write_config(input logic [7:0] ftype, input logic [7:0] fseq,
                                input logic [31:0] frand, input logic [15:0] flim);
        write_reg(CFG_FRAME_TYPE, {24'h0, ftype});
        write_reg(CFG_EXPECTED_SEQ, {24'h0, fseq});
        write_reg(CFG_SESSION_RANDOM, frand);
        write_reg(CFG_MAX_BODY_LENGTH, {16'h0, flim});
        cfg_we <= 1'b0;
    endtask

    // offer one byte, with an optional gap first, and hold it until taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (idling_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_rx_byte(b);
    endtask

    task automatic send_queued();
        while (tx_bytes.size() != 0)
            send_byte(tx_bytes.pop_front());
        in_valid <= 1'b0;
    endtask

    // wait for every awaited word, then let the pipeline empty
    task automatic settle();
        while (sb.awaited_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // build one frame from the current register copy, with the chosen defect
    task automatic queue_frame(input frame_kind_t kind, input logic [15:0] blen);
        int         total;
        int         bad_pos;
        logic [7:0] b;
        logic [7:0] acc;
        total   = (kind == FK_OVER_LIMIT) ? 3 : int'(blen) + 4;
        bad_pos = 3 + $urandom_range(0, 3);
        acc     = 8'h00;
        for (int p = 0; p < total; p++)
        begin
            if (p == 0)
                b = sb.cfg_type;
            else if (p == 1)
                b = blen[15:8];
            else if (p == 2)
                b = blen[7:0];
            else if (p <= 6)
                b = 8'(sb.cfg_random >> (8 * (6 - p)));
            else if (p == 7)
                b = sb.cfg_seq;
            else
                b = 8'($urandom);
            if (kind == FK_BAD_RANDOM && p == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            if (kind == FK_BAD_SEQ && p == 7)
                b = b ^ 8'($urandom_range(1, 255));
            // last byte zeroes the sum, or misses it on purpose
            if (p == total - 1 && kind != FK_SHORT && kind != FK_OVER_LIMIT)
            begin
                b = 8'h00 - acc;
                if (kind == FK_BAD_SUM)
                    b = b + 8'($urandom_range(1, 255));
            end
            acc = acc + b;
            tx_bytes.push_back(b);
        end
        frame_bytes += total;
    endtask

    // mostly well-formed frames, some defective, rejected, cut short or stray bytes
    task automatic queue_random_frame();
        int          pick;
        int          hi;
        int          cut;
        logic [15:0] blen;
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            // stray bytes, rarely equal to the type byte
            repeat ($urandom_range(1, 3)) tx_bytes.push_back(8'($urandom));
        end
        else if (pick < 14 && sb.cfg_max_len != 16'hFFFF)
        begin
            blen = 16'($urandom_range(int'(sb.cfg_max_len) + 1, 65535));
            queue_frame(FK_OVER_LIMIT, blen);
        end
        else if (pick < 24 || sb.cfg_max_len < MIN_BODY_LENGTH)
        begin
            hi   = (sb.cfg_max_len < 16'd4) ? int'(sb.cfg_max_len) : 4;
            blen = 16'($urandom_range(0, hi));
            queue_frame(FK_SHORT, blen);
        end
        else
        begin
            hi = ($urandom_range(0, 19) == 0) ? 400 : 20;
            if (int'(sb.cfg_max_len) < hi)
                hi = int'(sb.cfg_max_len);
            blen = 16'($urandom_range(5, hi));
            if (pick < 36)
                queue_frame(FK_BAD_SUM, blen);
            else if (pick < 46)
                queue_frame(FK_BAD_SEQ, blen);
            else if (pick < 56)
                queue_frame(FK_BAD_RANDOM, blen);
            else
            begin
                queue_frame(FK_OK, blen);
                // cut frame: the following bytes complete it
                if (pick >= 94)
                begin
                    cut = $urandom_range(1, int'(blen) + 3);
                    repeat (cut) void'(tx_bytes.pop_back());
                end
            end
        end
    endtask

    // status word receiver with random stalls and one long hold-off
    initial
    begin
        int stall_left;
        int hold_left;
        out_ready  = 1'b0;
        stall_left = 0;
        hold_left  = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_status_word(status, body_length, seen_seq);
            if (hold_long_req)
            begin
                hold_long_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // stimulus
    initial
    begin
        int          phase_no;
        int          frames;
        logic [15:0] lim;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_FRAME_TYPE;
        cfg_data      = '0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        idling_on     = 1'b1;
        hold_long_req = 1'b0;
        frame_bytes   = 0;
        sb            = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: stray extremes, too short, rejected header with no retry,
        // low length byte restarting a frame, high length byte restarting a frame
        write_config(8'h5A, 8'h3C, 32'hA5C3_0F96, 16'd6);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hFF);
        queue_frame(FK_SHORT, 16'd0);
        tx_bytes.push_back(8'h5A);
        tx_bytes.push_back(8'h01);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'h5A);
        tx_bytes.push_back(8'h01);
        queue_frame(FK_OK, 16'd5);
        tx_bytes.push_back(8'h5A);
        tx_bytes.push_back(8'h5A);
        tx_bytes.push_back(8'hFF);
        tx_bytes.push_back(8'h00);
        send_queued();
        settle();

        // random phases, each under its own register setting
        phase_no = 0;
        while (frame_bytes < ITEM_TARGET - FINAL_LEN - 4)
        begin
            phase_no++;
            idling_on = (phase_no % 5 != 0)
                        && (frame_bytes < ITEM_TARGET - FINAL_LEN - 250);
            frames    = $urandom_range(6, 14);
            if (phase_no == 1)
                write_config(8'h00, 8'h00, 32'h0000_0000, 16'hFFFF);
            else if (phase_no == 2)
                write_config(8'hFF, 8'hFF, 32'hFFFF_FFFF, 16'h0000);
            else
            begin
                case ($urandom_range(0, 9))
                    0:       lim = 16'hFFFF;
                    1:       lim = 16'd6;
                    2:       lim = 16'($urandom);
                    3:       lim = 16'($urandom_range(0, 4));
                    default: lim = 16'($urandom_range(5, 40));
                endcase
                if (phase_no == 4)
                    lim = 16'd6;
                write_config(8'($urandom), 8'($urandom), $urandom, lim);
            end
            if (phase_no == 4)
            begin
                // receiver holds off while back-to-back frames fill the block
                idling_on     = 1'b0;
                hold_long_req = 1'b1;
                repeat (30) queue_random_frame();
            end
            else
                repeat (frames) queue_random_frame();
            send_queued();
            settle();
        end

        // one long frame, no idling
        idling_on = 1'b0;
        write_config(8'($urandom), 8'($urandom), $urandom, 16'hFFFF);
        queue_frame(FK_OK, 16'(FINAL_LEN));
        send_queued();
        settle();

        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
